FILE: rtl/plsp_pkg.sv
// Shared types and constants for the pinned LRU slot pool.
package plsp_pkg;

    localparam logic [2:0] ACT_ALLOC    = 3'd0;
    localparam logic [2:0] ACT_ALLOC_NE = 3'd1;
    localparam logic [2:0] ACT_HIT      = 3'd2;
    localparam logic [2:0] ACT_TOUCH    = 3'd3;
    localparam logic [2:0] ACT_PIN      = 3'd4;
    localparam logic [2:0] ACT_UNPIN    = 3'd5;
    localparam logic [2:0] ACT_RELEASE  = 3'd6;
    localparam logic [2:0] ACT_SET_SPEC = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSLOT   = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_PIN_OF   = 3'd3;
    localparam logic [2:0] ST_UNPIN_UF = 3'd4;

    localparam logic [1:0] CFG_ACTIVE = 2'd0;
    localparam logic [1:0] CFG_HOT    = 2'd1;
    localparam logic [1:0] CFG_DECAY  = 2'd2;

    // index width of the largest pool that can be built
    localparam int IDXW = 10;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] slot;
        logic       spec_flag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_out;
        logic        evicted;
        logic        victim_was_speculative;
        logic [31:0] hit_count_out;
        logic [15:0] pin_count_out;
    } out_item_t;

    typedef struct packed {
        logic        used;
        logic [63:0] stamp;
        logic [15:0] pin;
        logic [31:0] pop;
        logic        spec;
    } slot_rec_t;

    typedef struct packed {
        logic            free_found;
        logic [IDXW-1:0] free_idx;
        logic [31:0]     free_pop;
        logic            spec_found;
        logic [IDXW-1:0] spec_idx;
        logic            cold_found;
        logic [IDXW-1:0] cold_idx;
        logic            any_found;
        logic [IDXW-1:0] any_idx;
    } scan_res_t;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_APPLY, S_FIN} state_t;

endpackage

FILE: rtl/pinned_lru_slot_pool_top.sv
// Top level: slot record ring, candidate scan, update and handshakes.
// Takes a new item only in idle. The record ring makes one full turn to scan
// candidates and one full turn to write back; the result then waits until the
// output register is free before the block returns to idle.
// Reset clears all slot records, the tick, the eviction count and restores
// active_slots 64, hot_threshold 0, decay_every 64; no clearing pass.
module pinned_lru_slot_pool_top
    import plsp_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IW   = $clog2(SLOTS);
    localparam int CMPW = (IW + 1 > 7) ? IW + 1 : 7;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    state_t      state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [63:0] tick_reg, tick_next;
    logic [15:0] esh_reg, esh_next;
    logic [6:0]  active_reg;
    logic [31:0] hot_reg;
    logic [15:0] decay_reg;
    in_item_t    item_reg;
    slot_rec_t   tgt_reg;
    out_item_t   res_reg, res_next;
    slot_rec_t   upd_rec_reg, upd_rec_next;
    logic [IW-1:0] upd_idx_reg, upd_idx_next;
    logic        upd_en_reg, upd_en_next;
    logic        halve_reg, halve_next;
    out_item_t   out_reg;
    logic        out_valid_reg, out_valid_next;
    logic        load_out;

    slot_rec_t   chain [SLOTS];
    slot_rec_t   tail, head_in;
    logic        shift;
    scan_res_t   sres;
    logic [CMPW-1:0] k_ext, live, act_ext, slot_ext;
    logic        k_in_range;
    logic        accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign shift     = (state_reg == S_SCAN) || (state_reg == S_APPLY);
    assign tail      = chain[SLOTS-1];

    assign k_ext      = CMPW'(k_reg);
    assign act_ext    = CMPW'(active_reg);
    assign live       = (act_ext > CMPW'(SLOTS)) ? CMPW'(SLOTS) : act_ext;
    assign slot_ext   = CMPW'(item_reg.slot);
    assign k_in_range = k_ext < live;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            plsp_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     ((gi == 0) ? head_in : chain[(gi == 0) ? 0 : gi - 1]),
                .q     (chain[gi])
            );
        end
    endgenerate

    plsp_scan #(.SLOTS(SLOTS)) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept),
        .step     (state_reg == S_SCAN),
        .k        (k_reg),
        .in_range (k_in_range),
        .hot      (hot_reg),
        .rec      (tail),
        .res      (sres)
    );

    // write-back on the second turn
    always_comb
    begin
        head_in = tail;
        if (state_reg == S_APPLY)
        begin
            if (upd_en_reg && (k_reg == upd_idx_reg))
            begin
                head_in = upd_rec_reg;
            end
            if (halve_reg && k_in_range)
            begin
                head_in.pop = head_in.pop >> 1;
            end
        end
    end

    // decision after the scan turn
    logic [IDXW-1:0] pick_idx;
    logic            pick_spec;
    logic            evict_ok;
    logic [15:0]     esh_inc;
    logic [63:0]     new_stamp;

    always_comb
    begin
        pick_idx  = sres.any_idx;
        pick_spec = 1'b0;
        if (sres.spec_found)
        begin
            pick_idx  = sres.spec_idx;
            pick_spec = 1'b1;
        end
        else if ((hot_reg != 32'd0) && sres.cold_found)
        begin
            pick_idx = sres.cold_idx;
        end
        evict_ok  = sres.spec_found || sres.any_found;
        esh_inc   = esh_reg + 16'd1;
        new_stamp = tick_reg + 64'd1;
    end

    always_comb
    begin
        res_next     = res_reg;
        upd_rec_next = upd_rec_reg;
        upd_idx_next = upd_idx_reg;
        upd_en_next  = upd_en_reg;
        halve_next   = halve_reg;
        tick_next    = tick_reg;
        esh_next     = esh_reg;
        if (state_reg == S_DECIDE)
        begin
            upd_en_next = 1'b0;
            halve_next  = 1'b0;
            res_next    = '0;
            if ((item_reg.action == ACT_ALLOC) || (item_reg.action == ACT_ALLOC_NE))
            begin
                if (sres.free_found)
                begin
                    upd_en_next        = 1'b1;
                    upd_idx_next       = sres.free_idx[IW-1:0];
                    upd_rec_next.used  = 1'b1;
                    upd_rec_next.stamp = new_stamp;
                    upd_rec_next.pin   = 16'd0;
                    upd_rec_next.pop   = sres.free_pop;
                    upd_rec_next.spec  = 1'b0;
                    tick_next          = new_stamp;
                    res_next.status        = ST_OK;
                    res_next.slot_out      = sres.free_idx[5:0];
                    res_next.hit_count_out = sres.free_pop;
                end
                else if ((item_reg.action == ACT_ALLOC) && evict_ok)
                begin
                    upd_en_next        = 1'b1;
                    upd_idx_next       = pick_idx[IW-1:0];
                    upd_rec_next.used  = 1'b1;
                    upd_rec_next.stamp = new_stamp;
                    upd_rec_next.pin   = 16'd0;
                    upd_rec_next.pop   = 32'd0;
                    upd_rec_next.spec  = 1'b0;
                    tick_next          = new_stamp;
                    if (esh_inc >= decay_reg)
                    begin
                        halve_next = 1'b1;
                        esh_next   = 16'd0;
                    end
                    else
                    begin
                        esh_next = esh_inc;
                    end
                    res_next.status                 = ST_OK;
                    res_next.slot_out               = pick_idx[5:0];
                    res_next.evicted                = 1'b1;
                    res_next.victim_was_speculative = pick_spec;
                end
                else
                begin
                    res_next.status = ST_NOSLOT;
                end
            end
            else if (slot_ext >= live)
            begin
                res_next.status   = ST_RANGE;
                res_next.slot_out = item_reg.slot;
            end
            else
            begin
                upd_en_next  = 1'b1;
                upd_idx_next = IW'(item_reg.slot);
                upd_rec_next = tgt_reg;
                res_next.status = ST_OK;
                case (item_reg.action)
                    ACT_HIT:
                    begin
                        upd_rec_next.stamp = new_stamp;
                        tick_next          = new_stamp;
                        upd_rec_next.spec  = 1'b0;
                        if (tgt_reg.pop != 32'hFFFF_FFFF)
                        begin
                            upd_rec_next.pop = tgt_reg.pop + 32'd1;
                        end
                    end
                    ACT_TOUCH:
                    begin
                        upd_rec_next.stamp = new_stamp;
                        tick_next          = new_stamp;
                    end
                    ACT_PIN:
                    begin
                        if (tgt_reg.pin == 16'hFFFF)
                        begin
                            res_next.status = ST_PIN_OF;
                        end
                        else
                        begin
                            upd_rec_next.pin = tgt_reg.pin + 16'd1;
                        end
                    end
                    ACT_UNPIN:
                    begin
                        if (tgt_reg.pin == 16'd0)
                        begin
                            res_next.status = ST_UNPIN_UF;
                        end
                        else
                        begin
                            upd_rec_next.pin = tgt_reg.pin - 16'd1;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        upd_rec_next.spec = 1'b0;
                        upd_rec_next.used = 1'b0;
                    end
                    default:
                    begin
                        upd_rec_next.spec = item_reg.spec_flag;
                    end
                endcase
                res_next.slot_out      = item_reg.slot;
                res_next.hit_count_out = upd_rec_next.pop;
                res_next.pin_count_out = upd_rec_next.pin;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == LAST)
                begin
                    k_next     = '0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == LAST)
                begin
                    k_next     = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            tick_reg      <= '0;
            esh_reg       <= '0;
            active_reg    <= 7'd64;
            hot_reg       <= '0;
            decay_reg     <= 16'd64;
            out_valid_reg <= 1'b0;
            upd_en_reg    <= 1'b0;
            halve_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            tick_reg      <= tick_next;
            esh_reg       <= esh_next;
            out_valid_reg <= out_valid_next;
            upd_en_reg    <= upd_en_next;
            halve_reg     <= halve_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ACTIVE: active_reg <= cfg_data[6:0];
                    CFG_HOT:    hot_reg    <= cfg_data;
                    CFG_DECAY:  decay_reg  <= cfg_data[15:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if ((state_reg == S_SCAN) && (k_ext == slot_ext))
        begin
            tgt_reg <= tail;
        end
        res_reg     <= res_next;
        upd_rec_reg <= upd_rec_next;
        upd_idx_reg <= upd_idx_next;
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_scan_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && (k_reg == LAST) |=> (state_reg == S_DECIDE))
        else $error("scan turn did not end in decide");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN) && (k_reg == '0))
        else $error("accepted item did not start a scan");

    a_tick_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_reg != $past(tick_reg)) |-> $past(state_reg == S_DECIDE))
        else $error("tick moved outside decide");

    a_noslot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == ST_NOSLOT) |->
            (out_reg.slot_out == 6'd0) && (out_reg.hit_count_out == 32'd0)
            && (out_reg.pin_count_out == 16'd0))
        else $error("failed allocation carries nonzero fields");

endmodule

FILE: rtl/plsp_cell.sv
// One slot record in the circulating chain.
module plsp_cell
    import plsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift,
    input  slot_rec_t d,
    output slot_rec_t q
);

    slot_rec_t rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else if (shift)
        begin
            rec_reg <= d;
        end
    end

    assign q = rec_reg;

endmodule

FILE: rtl/plsp_scan.sv
// Candidate tracker: sees one slot per cycle at the chain tail while step is high.
module plsp_scan
    import plsp_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       step,
    input  logic [$clog2(SLOTS)-1:0]   k,
    input  logic                       in_range,
    input  logic [31:0]                hot,
    input  slot_rec_t                  rec,
    output scan_res_t                  res
);

    localparam int IW = $clog2(SLOTS);

    scan_res_t   res_reg;
    scan_res_t   res_next;
    logic [63:0] spec_t_reg, cold_t_reg, any_t_reg;
    logic [63:0] spec_t_next, cold_t_next, any_t_next;
    logic [IDXW-1:0] k_ext;
    logic        cand;

    assign k_ext = {{(IDXW-IW){1'b0}}, k};
    assign cand  = step && in_range && (rec.pin == 16'd0);

    always_comb
    begin
        res_next    = res_reg;
        spec_t_next = spec_t_reg;
        cold_t_next = cold_t_reg;
        any_t_next  = any_t_reg;
        if (clear)
        begin
            res_next.free_found = 1'b0;
            res_next.spec_found = 1'b0;
            res_next.cold_found = 1'b0;
            res_next.any_found  = 1'b0;
        end
        else
        begin
            if (cand && !rec.used && !res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = k_ext;
                res_next.free_pop   = rec.pop;
            end
            // strict compare keeps the lowest index on ties
            if (cand && rec.spec && (!res_reg.spec_found || rec.stamp < spec_t_reg))
            begin
                res_next.spec_found = 1'b1;
                res_next.spec_idx   = k_ext;
                spec_t_next         = rec.stamp;
            end
            if (cand && !(rec.pop > hot) && (!res_reg.cold_found || rec.stamp < cold_t_reg))
            begin
                res_next.cold_found = 1'b1;
                res_next.cold_idx   = k_ext;
                cold_t_next         = rec.stamp;
            end
            if (cand && (!res_reg.any_found || rec.stamp < any_t_reg))
            begin
                res_next.any_found = 1'b1;
                res_next.any_idx   = k_ext;
                any_t_next         = rec.stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spec_t_reg <= spec_t_next;
        cold_t_reg <= cold_t_next;
        any_t_reg  <= any_t_next;
    end

    assign res = res_reg;

endmodule
